FILE: rtl/first_fit_block_allocator_macros.svh
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// Holds at every clock edge outside reset.
`define FFBA_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("allocator check failed");
// The consequent holds in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define FFBA_ASSERT(lbl, cond)
`define FFBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/ffba_pkg.sv
package ffba_pkg;

    // Default sizing of the arena and the block table.
    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_BLOCKS_DEF   = 128;

    // Fixed field widths of the channels.
    localparam int ARG_W = 13;
    localparam int OFF_W = 12;
    localparam int FB_W  = 13;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // A classified request as it waits in the queue.
    typedef struct packed {
        t_op              op;
        logic             bad;
        logic [ARG_W-1:0] arg;
    } t_cmd;

endpackage

FILE: rtl/ffba_front.sv
`include "first_fit_block_allocator_macros.svh"

module ffba_front import ffba_pkg::*; #(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_opcode,
    input  logic [ARG_W-1:0] i_operand,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_pop
);

    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_cmd       r_q [2];
    t_cmd       cmd_in;
    logic       push;

    // Classify the incoming item: a free below one header can never name a payload.
    always_comb begin
        cmd_in.op  = t_op'(i_opcode);
        cmd_in.arg = i_operand;
        cmd_in.bad = (t_op'(i_opcode) == OP_FREE) && (i_operand < ARG_W'(HEADER_BYTES));
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Two-entry queue between the input channel and the table engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop && o_cmd_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    `FFBA_ASSERT(a_q_bound, r_cnt != 2'd3)
    `FFBA_ASSERT(a_pop_nonempty, !i_cmd_pop || o_cmd_valid)
    `FFBA_ASSERT_NEXT(a_push_fills, push && !(i_cmd_pop && o_cmd_valid), r_cnt != 2'd0)

endmodule

FILE: rtl/ffba_back.sv
`include "first_fit_block_allocator_macros.svh"

module ffba_back import ffba_pkg::*; #(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ARG_W-1:0] i_cfg_wdata,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_ok,
    output logic [OFF_W-1:0] o_offset,
    output logic [FB_W-1:0]  o_free_bytes
);

    localparam int SW     = $clog2(ARENA_BYTES + 1);
    localparam int IW     = $clog2(MAX_BLOCKS);
    localparam int CW     = $clog2(MAX_BLOCKS + 2);
    localparam int CALC_W = ((SW > ARG_W) ? SW : ARG_W) + 2;
    localparam int ENT_W  = 2 * SW + 1;
    localparam logic [CALC_W-1:0] HDR   = CALC_W'(HEADER_BYTES);
    localparam logic [CALC_W-1:0] ARENA = CALC_W'(ARENA_BYTES);

    typedef enum logic [9:0] {
        ST_INIT = 10'b0000000001,
        ST_IDLE = 10'b0000000010,
        ST_SCAN = 10'b0000000100,
        ST_AHIT = 10'b0000001000,
        ST_SHUP = 10'b0000010000,
        ST_SPL0 = 10'b0000100000,
        ST_SPL1 = 10'b0001000000,
        ST_FNXT = 10'b0010000000,
        ST_SHDN = 10'b0100000000,
        ST_RES  = 10'b1000000000
    } t_state;

    // Block table: {free, payload size, header offset} per entry.
    logic [ENT_W-1:0] r_mem [MAX_BLOCKS];
    logic [ENT_W-1:0] r_rdata;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [SW-1:0]    r_avail, n_avail;
    logic [CALC_W-1:0] r_arena, n_arena;
    t_cmd             r_cmd, n_cmd;
    logic [CW-1:0]    r_ra, n_ra;
    logic [IW-1:0]    r_pa, n_pa;
    logic             r_dv, n_dv;
    logic [IW-1:0]    r_i, n_i;
    logic [ENT_W-1:0] r_e, n_e;
    logic [ENT_W-1:0] r_p, n_p;
    logic [CW-1:0]    r_src, n_src;
    logic [IW-1:0]    r_wa, n_wa;
    logic [CW-1:0]    r_gap, n_gap;
    logic [CW-1:0]    r_lim, n_lim;
    logic             r_rok, n_rok;
    logic [OFF_W-1:0] r_roff, n_roff;
    logic             r_ovld, n_ovld;
    logic             r_ook, n_ook;
    logic [OFF_W-1:0] r_ooff, n_ooff;
    logic [FB_W-1:0]  r_ofb, n_ofb;

    logic [CALC_W-1:0] arg_c, need_c, lim_c, pay_c;
    logic [CALC_W-1:0] rd_start_c, rd_size_c, e_start_c, e_size_c, p_size_c;
    logic              rd_free, p_free;
    logic              hit_alloc, hit_free, last_pa, has_next, has_prev, nxt_free;

    // Field views of the read data and the held entries.
    assign rd_start_c = CALC_W'(r_rdata[SW-1:0]);
    assign rd_size_c  = CALC_W'(r_rdata[2*SW-1:SW]);
    assign rd_free    = r_rdata[2*SW];
    assign e_start_c  = CALC_W'(r_e[SW-1:0]);
    assign e_size_c   = CALC_W'(r_e[2*SW-1:SW]);
    assign p_size_c   = CALC_W'(r_p[2*SW-1:SW]);
    assign p_free     = r_p[2*SW];

    assign arg_c  = CALC_W'(r_cmd.arg);
    assign need_c = arg_c + HDR;
    assign lim_c  = (r_arena > ARENA) ? ARENA : r_arena;
    assign pay_c  = (lim_c > HDR) ? (lim_c - HDR) : '0;

    assign hit_alloc = rd_free && (rd_size_c >= arg_c);
    assign hit_free  = ((rd_start_c + HDR) == arg_c);
    assign last_pa   = (CW'(r_pa) == (r_cnt - 1'b1));
    assign has_next  = ((CW'(r_i) + 1'b1) < r_cnt);
    assign has_prev  = (r_i != '0) && p_free;
    assign nxt_free  = has_next && rd_free;

    // Sequencer over the table.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_avail = r_avail;
        n_arena = r_arena;
        n_cmd   = r_cmd;
        n_ra    = r_ra;
        n_pa    = r_pa;
        n_dv    = r_dv;
        n_i     = r_i;
        n_e     = r_e;
        n_p     = r_p;
        n_src   = r_src;
        n_wa    = r_wa;
        n_gap   = r_gap;
        n_lim   = r_lim;
        n_rok   = r_rok;
        n_roff  = r_roff;
        n_ovld  = r_ovld && !i_ready;
        n_ook   = r_ook;
        n_ooff  = r_ooff;
        n_ofb   = r_ofb;
        rd_addr = r_ra[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_i;
        wr_data = r_e;
        o_cmd_pop = 1'b0;

        case (r_state)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {1'b1, SW'(pay_c), {SW{1'b0}}};
                n_cnt   = CW'(1);
                n_avail = SW'(pay_c);
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_ra      = '0;
                    n_dv      = 1'b0;
                    if (i_cmd.op == OP_FREE && i_cmd.bad) begin
                        n_rok   = 1'b0;
                        n_roff  = '0;
                        n_state = ST_RES;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_dv && r_cmd.op == OP_ALLOC && hit_alloc) begin
                    n_i     = r_pa;
                    n_e     = r_rdata;
                    n_dv    = 1'b0;
                    n_state = ST_AHIT;
                end else if (r_dv && r_cmd.op == OP_FREE && hit_free) begin
                    n_i     = r_pa;
                    n_e     = r_rdata;
                    n_dv    = 1'b0;
                    rd_addr = r_pa + 1'b1;
                    if (rd_free) begin
                        n_rok   = 1'b0;
                        n_roff  = '0;
                        n_state = ST_RES;
                    end else begin
                        n_state = ST_FNXT;
                    end
                end else if (r_dv && last_pa) begin
                    n_rok   = 1'b0;
                    n_roff  = '0;
                    n_dv    = 1'b0;
                    n_state = ST_RES;
                end else begin
                    if (r_dv) begin
                        n_p = r_rdata;
                    end
                    if (r_ra < r_cnt) begin
                        n_dv = 1'b1;
                        n_pa = r_ra[IW-1:0];
                        n_ra = r_ra + 1'b1;
                    end else begin
                        n_dv = 1'b0;
                    end
                end
            end
            ST_AHIT: begin
                n_rok  = 1'b1;
                n_roff = OFF_W'(e_start_c + HDR);
                if (e_size_c <= need_c || r_cnt >= CW'(MAX_BLOCKS)) begin
                    wr_en   = 1'b1;
                    wr_data = {1'b0, r_e[2*SW-1:0]};
                    n_avail = r_avail - r_e[2*SW-1:SW];
                    n_state = ST_RES;
                end else begin
                    n_src   = r_cnt - 1'b1;
                    n_dv    = 1'b0;
                    n_state = ST_SHUP;
                end
            end
            ST_SHUP: begin
                // Move entries above the split point up by one, one per cycle.
                wr_en   = r_dv;
                wr_addr = r_wa;
                wr_data = r_rdata;
                if (r_src > CW'(r_i)) begin
                    rd_addr = r_src[IW-1:0];
                    n_dv    = 1'b1;
                    n_wa    = IW'(r_src + 1'b1);
                    n_src   = r_src - 1'b1;
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_state = ST_SPL0;
                    end
                end
            end
            ST_SPL0: begin
                wr_en   = 1'b1;
                wr_data = {1'b0, SW'(arg_c), r_e[SW-1:0]};
                n_state = ST_SPL1;
            end
            ST_SPL1: begin
                wr_en   = 1'b1;
                wr_addr = r_i + 1'b1;
                wr_data = {1'b1, SW'(e_size_c - need_c), SW'(e_start_c + need_c)};
                n_cnt   = r_cnt + 1'b1;
                n_avail = r_avail - SW'(need_c);
                n_state = ST_RES;
            end
            ST_FNXT: begin
                // Next entry is on the read port; write the freed block, merged with any free neighbour.
                n_rok  = 1'b1;
                n_roff = '0;
                n_lim  = r_cnt;
                n_dv   = 1'b0;
                wr_en  = 1'b1;
                if (has_prev && nxt_free) begin
                    wr_addr = r_i - 1'b1;
                    wr_data = {1'b1, SW'(p_size_c + e_size_c + rd_size_c + HDR + HDR),
                               r_p[SW-1:0]};
                    n_avail = r_avail + SW'(e_size_c + HDR + HDR);
                    n_src   = CW'(r_i) + CW'(2);
                    n_gap   = CW'(2);
                    n_state = ST_SHDN;
                end else if (has_prev) begin
                    wr_addr = r_i - 1'b1;
                    wr_data = {1'b1, SW'(p_size_c + e_size_c + HDR), r_p[SW-1:0]};
                    n_avail = r_avail + SW'(e_size_c + HDR);
                    n_src   = CW'(r_i) + CW'(1);
                    n_gap   = CW'(1);
                    n_state = ST_SHDN;
                end else if (nxt_free) begin
                    wr_data = {1'b1, SW'(e_size_c + rd_size_c + HDR), r_e[SW-1:0]};
                    n_avail = r_avail + SW'(e_size_c + HDR);
                    n_src   = CW'(r_i) + CW'(2);
                    n_gap   = CW'(1);
                    n_state = ST_SHDN;
                end else begin
                    wr_data = {1'b1, r_e[2*SW-1:0]};
                    n_avail = r_avail + r_e[2*SW-1:SW];
                    n_state = ST_RES;
                end
            end
            ST_SHDN: begin
                // Close the gap left by merged entries, one entry per cycle.
                wr_en   = r_dv;
                wr_addr = r_wa;
                wr_data = r_rdata;
                if (r_src < r_lim) begin
                    rd_addr = r_src[IW-1:0];
                    n_dv    = 1'b1;
                    n_wa    = IW'(r_src - r_gap);
                    n_src   = r_src + 1'b1;
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_cnt   = r_lim - r_gap;
                        n_state = ST_RES;
                    end
                end
            end
            ST_RES: begin
                if (!r_ovld || i_ready) begin
                    n_ovld  = 1'b1;
                    n_ook   = r_rok;
                    n_ooff  = r_roff;
                    n_ofb   = FB_W'(CALC_W'(r_avail));
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase

        // A new arena size rebuilds the table from a single free block.
        if (i_cfg_we) begin
            n_arena = CALC_W'(i_cfg_wdata);
            n_state = ST_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= CW'(1);
            r_avail <= '0;
            r_arena <= ARENA;
            r_dv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_avail <= n_avail;
            r_arena <= n_arena;
            r_dv    <= n_dv;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_ra   <= n_ra;
        r_pa   <= n_pa;
        r_i    <= n_i;
        r_e    <= n_e;
        r_p    <= n_p;
        r_src  <= n_src;
        r_wa   <= n_wa;
        r_gap  <= n_gap;
        r_lim  <= n_lim;
        r_rok  <= n_rok;
        r_roff <= n_roff;
        r_ook  <= n_ook;
        r_ooff <= n_ooff;
        r_ofb  <= n_ofb;
    end

    assign o_valid      = r_ovld;
    assign o_ok         = r_ook;
    assign o_offset     = r_ooff;
    assign o_free_bytes = r_ofb;

    `FFBA_ASSERT(a_cnt_range, (r_cnt != '0) && (r_cnt <= CW'(MAX_BLOCKS)))
    `FFBA_ASSERT(a_split_room, (r_state != ST_SHUP) || (r_cnt < CW'(MAX_BLOCKS)))
    `FFBA_ASSERT(a_fail_no_off, !r_ovld || r_ook || (r_ooff == '0))
    `FFBA_ASSERT_NEXT(a_pop_scans, o_cmd_pop,
        (r_state == ST_SCAN) || (r_state == ST_RES) || (r_state == ST_INIT))

endmodule

FILE: rtl/first_fit_block_allocator.sv
// First-fit block allocator with coalescing of free neighbours.
// Requests enter on i_valid/o_ready with i_opcode (0 allocate, 1 free) and
// i_operand (payload bytes, or the payload offset to release). Each request
// gives exactly one result on o_valid/i_ready: o_ok, o_offset (payload
// offset of a new block, else 0) and o_free_bytes after the request.
// A two-entry queue decouples the input channel from the table engine, which
// keeps blocks in an address-ordered table with one read and one write port
// and walks it one entry per cycle up to the entry that matches. A split then
// moves every entry above it up by one, and a merge moves every entry above
// the merged block down, again one entry per cycle.
// Reset, or a write on i_cfg_we/i_cfg_wdata, rebuilds the arena as one free
// block; write the size only while no request is in flight.
// The result register holds while i_ready is low; the engine then waits with
// the next result, and the queue keeps taking up to two items.
module first_fit_block_allocator import ffba_pkg::*; #(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ARG_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_opcode,
    input  logic [ARG_W-1:0] i_operand,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_ok,
    output logic [OFF_W-1:0] o_offset,
    output logic [FB_W-1:0]  o_free_bytes
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    ffba_front #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_opcode   (i_opcode),
        .i_operand  (i_operand),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    ffba_back #(
        .ARENA_BYTES (ARENA_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_ok        (o_ok),
        .o_offset    (o_offset),
        .o_free_bytes(o_free_bytes)
    );

endmodule
